@@ design/crfb_pkg.sv @@
// ----------------------------------------------------------------------------
// crfb_pkg: shared types and constants for the cube root fraction block
// Widths of the digit-by-digit root chain and the payload record that
// travels from one root cell to the next.
// ----------------------------------------------------------------------------
package crfb_pkg;

  // field widths
  localparam int INPUT_BITS    = 16;
  localparam int FRACTION_BITS = 32;

  // three radicand bits per root bit; integer groups then fraction groups
  localparam int IN_GROUPS = (INPUT_BITS + 2) / 3;
  localparam int STEPS     = IN_GROUPS + FRACTION_BITS;

  // radicand shifter, root, square of root, remainder and compare widths
  localparam int RAD_W  = 3 * IN_GROUPS;
  localparam int ROOT_W = STEPS;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int REM_W  = 2 * ROOT_W + 2;
  localparam int CMP_W  = REM_W + 3;

  // stream bus widths, whole bytes
  localparam int IN_TDATA_W  = ((INPUT_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((FRACTION_BITS + 7) / 8) * 8;

  // partial result handed along the cell chain
  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // radicand groups not yet consumed, top first
    logic [REM_W-1:0]  rem;   // running remainder
    logic [ROOT_W-1:0] root;  // root bits found so far
    logic [SQ_W-1:0]   sq;    // square of root, kept to avoid a multiplier
  } data_t;

endpackage

@@ design/crfb_cell.sv @@
// ----------------------------------------------------------------------------
// crfb_cell: one root bit of the integer cube root
// Brings in the next three radicand bits, tries root bit one against the
// remainder and registers the updated remainder, root and root squared.
// ----------------------------------------------------------------------------
module crfb_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,       // whole chain moves one place
  input  logic            valid_i,
  input  crfb_pkg::data_t data_i,
  output logic            valid_o,
  output crfb_pkg::data_t data_o
);

  logic [2:0]                     grp;
  logic [crfb_pkg::CMP_W-1:0]     rem_sh;
  logic [crfb_pkg::CMP_W-1:0]     trial;
  logic [crfb_pkg::CMP_W-1:0]     diff;
  logic                           take;
  logic [crfb_pkg::SQ_W-1:0]      sq_shl;
  logic [crfb_pkg::SQ_W-1:0]      sq_grow;
  logic                           valid_r;
  crfb_pkg::data_t                data_r;
  crfb_pkg::data_t                data_nxt;

  // next radicand group and shifted remainder
  assign grp    = data_i.rad[crfb_pkg::RAD_W-1 -: 3];
  assign rem_sh = {data_i.rem, grp};

  // trial term 3*(2y)*(2y+1)+1 = 12*y^2 + 6*y + 1
  assign trial = (crfb_pkg::CMP_W'(data_i.sq) << 3) + (crfb_pkg::CMP_W'(data_i.sq) << 2)
               + (crfb_pkg::CMP_W'(data_i.root) << 2) + (crfb_pkg::CMP_W'(data_i.root) << 1)
               + crfb_pkg::CMP_W'(1);
  assign take  = (rem_sh >= trial);
  assign diff  = rem_sh - trial;

  // (2y+1)^2 = 4*y^2 + 4*y + 1, or 4*y^2 when the bit stays zero
  assign sq_shl  = data_i.sq << 2;
  assign sq_grow = sq_shl + (crfb_pkg::SQ_W'(data_i.root) << 2) + crfb_pkg::SQ_W'(1);

  always_comb begin
    data_nxt.rad  = data_i.rad << 3;
    data_nxt.rem  = take ? diff[crfb_pkg::REM_W-1:0] : rem_sh[crfb_pkg::REM_W-1:0];
    data_nxt.root = {data_i.root[crfb_pkg::ROOT_W-2:0], take};
    data_nxt.sq   = take ? sq_grow : sq_shl;
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

endmodule

@@ design/cube_root_fraction_bits.sv @@
// ----------------------------------------------------------------------------
// cube_root_fraction_bits: first fraction bits of the cube root of n
// Exact low bits of floor(cbrt(n * 2^(3*FRACTION_BITS))) from a chain of
// root cells, one root bit per cell, followed by an output register.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata fields (lowest bit up)   | transfer
//  in_     | slave     | value [15:0]                   | in_tvalid & in_tready
//  out_    | master    | fraction_bits [31:0]           | out_tvalid & out_tready
//
//  path: the 38 root cells (one root bit each over 6 integer and 32 fraction
//  groups) followed by the output register, the first cell loading at the
//  input transfer edge.
//  throughput: one item per cycle while the output is taken; up to 39 items
//  in flight.
//  stalls: when the output register holds an untaken result, the chain and
//  in_tready freeze together.
//  reset: clears the cell occupancy flags and the output valid.
//
module cube_root_fraction_bits (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [crfb_pkg::IN_TDATA_W-1:0]  in_tdata,   // value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [crfb_pkg::OUT_TDATA_W-1:0] out_tdata   // fraction_bits
);

  logic                                 en;
  logic                                 chain_valid [0:crfb_pkg::STEPS];
  crfb_pkg::data_t                      chain_data  [0:crfb_pkg::STEPS];
  logic                                 out_valid_r;
  logic [crfb_pkg::FRACTION_BITS-1:0]   out_data_r;

  // chain moves whenever the output slot is free or being emptied
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // head of the chain: fresh radicand, cleared remainder and root
  assign chain_valid[0]     = in_tvalid;
  assign chain_data[0].rad  = crfb_pkg::RAD_W'(in_tdata[crfb_pkg::INPUT_BITS-1:0]);
  assign chain_data[0].rem  = '0;
  assign chain_data[0].root = '0;
  assign chain_data[0].sq   = '0;

  // root cells
  for (genvar k = 0; k < crfb_pkg::STEPS; k++) begin : g_cell
    crfb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (chain_valid[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  // output register flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= chain_valid[crfb_pkg::STEPS];
    end
  end

  // output register data, integer part dropped
  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= chain_data[crfb_pkg::STEPS].root[crfb_pkg::FRACTION_BITS-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = crfb_pkg::OUT_TDATA_W'(out_data_r);

  // an input transfer occupies the first cell
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> chain_valid[1])
    else $error("accepted item did not enter the first cell");

  // a finished item moves into the output register when the chain moves
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    en && chain_valid[crfb_pkg::STEPS] |=> out_valid_r)
    else $error("finished item lost at the output register");

  // a stalled chain keeps its last cell intact
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(chain_valid[crfb_pkg::STEPS]) && $stable(chain_data[crfb_pkg::STEPS]))
    else $error("chain moved during an output stall");

endmodule
